// ===== src/stm_pkg.sv =====
// shared types, constants and helper functions for the sparse table range min/max unit
`default_nettype none
package stm_pkg;

    localparam int MAX_LENGTH  = 1024;
    localparam int LEVELS      = 11;
    localparam int VALUE_WIDTH = 32;

    localparam int VAL_W  = 32;
    localparam int IDX_W  = 10;
    localparam int LEN_W  = 11;
    localparam int SEXT_W = (VALUE_WIDTH < VAL_W) ? VALUE_WIDTH : VAL_W;

    localparam int ROW_W  = $clog2(MAX_LENGTH);
    localparam int LVL_W  = $clog2(LEVELS + 1);
    localparam int DEPTH  = LEVELS * MAX_LENGTH;
    localparam int ADDR_W = $clog2(DEPTH);

    localparam int EFF_CAP = (MAX_LENGTH < ((1 << LEVELS) - 1)) ? MAX_LENGTH
                                                                : ((1 << LEVELS) - 1);

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_BUILD = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_BAD     = 2'd1;
    localparam logic [1:0] STATUS_UNBUILT = 2'd2;

    typedef struct packed {
        logic [1:0]              cmd;
        logic [IDX_W-1:0]        left_index;
        logic [IDX_W-1:0]        right_index;
        logic signed [VAL_W-1:0] value_a;
        logic signed [VAL_W-1:0] value_b;
    } t_in;

    typedef struct packed {
        logic signed [VAL_W-1:0] range_min;
        logic signed [VAL_W-1:0] range_max;
        logic [1:0]              status;
    } t_out;

    typedef struct packed {
        logic signed [VAL_W-1:0] mn;
        logic signed [VAL_W-1:0] mx;
    } t_entry;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        t_entry            wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr0;
        logic [ADDR_W-1:0] raddr1;
    } t_ram_req;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_QRES,
        ST_BRD,
        ST_BWR
    } t_state;

    function automatic logic signed [VAL_W-1:0] sext_val(input logic signed [VAL_W-1:0] x);
        logic signed [SEXT_W-1:0] t;
        t = x[SEXT_W-1:0];
        return VAL_W'(t);
    endfunction

    function automatic t_entry merge(input t_entry a, input t_entry b);
        t_entry m;
        m.mn = (a.mn < b.mn) ? a.mn : b.mn;
        m.mx = (a.mx > b.mx) ? a.mx : b.mx;
        return m;
    endfunction

    function automatic logic [LVL_W-1:0] flog2(input logic [LEN_W-1:0] v);
        logic [LVL_W-1:0] k;
        k = '0;
        for (int i = 0; i < LEN_W; i++) begin
            if (v[i]) begin
                k = LVL_W'(i);
            end
        end
        return k;
    endfunction

    function automatic logic [ADDR_W-1:0] tbl_addr(input logic [LVL_W-1:0] k,
                                                   input logic [ROW_W-1:0] row);
        return ADDR_W'(int'(k) * MAX_LENGTH + int'(row));
    endfunction

endpackage
`default_nettype wire

// ===== src/sparse_table_range_min_max_unit.sv =====
// top level of the sparse table range min/max unit: length register, sequencer, table ram
// load, build-less query and bad items give a registered result in the cycle after the transfer
// a valid query reads the table ram, then merges the two entries in ST_QRES; no new item is taken until idle
// build: ram read in ST_BRD then write in ST_BWR for each table entry filled, and a level step at each level end
// reset: no item in flight, length 1, tables not built, table contents undefined
`default_nettype none
module sparse_table_range_min_max_unit
    import stm_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire t_in              i_in_data,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output t_out                  o_out_data,
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [LEN_W-1:0] i_cfg_data
);

    logic [LEN_W-1:0] r_len;
    logic [LEN_W-1:0] eff_len;
    logic             cfg_wr;
    t_ram_req         ram_req;
    t_entry           rdata0;
    t_entry           rdata1;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= LEN_W'(1);
        end else if (cfg_wr) begin
            r_len <= i_cfg_data;
        end
    end

    // length in use, capped so every level a query needs exists
    always_comb begin
        eff_len = r_len;
        if (int'(r_len) > EFF_CAP) begin
            eff_len = LEN_W'(EFF_CAP);
        end
    end

    stm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_len       (eff_len),
        .i_cfg_wr    (cfg_wr),
        .o_ram_req   (ram_req),
        .i_rdata0    (rdata0),
        .i_rdata1    (rdata1)
    );

    stm_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk    (i_clk),
        .i_we     (ram_req.we),
        .i_waddr  (ram_req.waddr),
        .i_wdata  (ram_req.wdata),
        .i_re     (ram_req.re),
        .i_raddr0 (ram_req.raddr0),
        .i_raddr1 (ram_req.raddr1),
        .o_rdata0 (rdata0),
        .o_rdata1 (rdata1)
    );

endmodule
`default_nettype wire

// ===== src/stm_ram.sv =====
// generic synchronous ram, one write port and two registered read ports
`default_nettype none
module stm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr0,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr1,
    output logic      [WIDTH-1:0]         o_rdata0,
    output logic      [WIDTH-1:0]         o_rdata1
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata0 <= r_mem[i_raddr0];
            o_rdata1 <= r_mem[i_raddr1];
        end
    end

endmodule
`default_nettype wire

// ===== src/stm_ctrl.sv =====
// command sequencer: loads, table build walk, queries and the result register
`default_nettype none
module stm_ctrl
    import stm_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire t_in              i_in_data,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output t_out                  o_out_data,
    input  wire logic [LEN_W-1:0] i_len,
    input  wire logic             i_cfg_wr,
    output t_ram_req              o_ram_req,
    input  wire t_entry           i_rdata0,
    input  wire t_entry           i_rdata1
);

    t_state           r_state, n_state;
    logic             r_built, n_built;
    logic             r_out_valid, n_out_valid;
    t_out             r_out, n_out;
    logic [LVL_W-1:0] r_k, n_k;
    logic [ROW_W-1:0] r_j, n_j;

    logic             in_acc;
    logic             out_free;
    logic             res_en;
    logic [LEN_W-1:0] q_len;
    logic [LVL_W-1:0] q_k;
    logic [ROW_W-1:0] q_row1;
    logic             q_bad;
    logic             lvl_done;
    logic             build_end;
    t_entry           merged;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = !((r_state == ST_IDLE) && out_free);
    assign in_acc     = i_in_valid && !o_in_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign q_len  = LEN_W'({1'b0, i_in_data.right_index} - {1'b0, i_in_data.left_index} + 1'b1);
    assign q_k    = flog2(q_len);
    assign q_row1 = ROW_W'(int'(i_in_data.right_index) + 1 - (1 << q_k));
    assign q_bad  = (i_in_data.left_index > i_in_data.right_index)
                 || ({1'b0, i_in_data.right_index} >= i_len);

    assign lvl_done  = (r_k == LVL_W'(LEVELS)) || ((int'(r_j) + (1 << r_k)) > int'(i_len));
    assign build_end = lvl_done && ((r_j == '0) || (r_k == LVL_W'(LEVELS)));
    assign merged    = merge(i_rdata0, i_rdata1);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_in_data.cmd == CMD_BUILD) begin
                        n_state = ST_BRD;
                    end else if ((i_in_data.cmd == CMD_QUERY) && r_built && !q_bad) begin
                        n_state = ST_QRES;
                    end
                end
            end
            ST_QRES: n_state = ST_IDLE;
            ST_BRD: begin
                if (build_end) begin
                    n_state = ST_IDLE;
                end else if (!lvl_done) begin
                    n_state = ST_BWR;
                end
            end
            ST_BWR:  n_state = ST_BRD;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ram_req = '0;
        n_k       = r_k;
        n_j       = r_j;
        n_built   = r_built;
        n_out     = r_out;
        res_en    = 1'b0;
        if (i_cfg_wr) begin
            n_built = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    case (i_in_data.cmd)
                        CMD_LOAD: begin
                            res_en  = 1'b1;
                            n_built = 1'b0;
                            n_out   = '{range_min: '0, range_max: '0, status: STATUS_BAD};
                            if (int'(i_in_data.left_index) < MAX_LENGTH) begin
                                o_ram_req.we       = 1'b1;
                                o_ram_req.waddr    = tbl_addr('0, ROW_W'(i_in_data.left_index));
                                o_ram_req.wdata.mn = sext_val(i_in_data.value_a);
                                o_ram_req.wdata.mx = sext_val(i_in_data.value_b);
                                n_out.status       = STATUS_OK;
                            end
                        end
                        CMD_BUILD: begin
                            n_built = 1'b1;
                            n_k     = LVL_W'(1);
                            n_j     = '0;
                        end
                        CMD_QUERY: begin
                            n_out = '{range_min: '0, range_max: '0, status: STATUS_OK};
                            if (!r_built) begin
                                res_en       = 1'b1;
                                n_out.status = STATUS_UNBUILT;
                            end else if (q_bad) begin
                                res_en       = 1'b1;
                                n_out.status = STATUS_BAD;
                            end else begin
                                o_ram_req.re     = 1'b1;
                                o_ram_req.raddr0 = tbl_addr(q_k, ROW_W'(i_in_data.left_index));
                                o_ram_req.raddr1 = tbl_addr(q_k, q_row1);
                            end
                        end
                        default: begin
                            res_en = 1'b1;
                            n_out  = '{range_min: '0, range_max: '0, status: STATUS_BAD};
                        end
                    endcase
                end
            end
            ST_QRES: begin
                res_en = 1'b1;
                n_out  = '{range_min: merged.mn, range_max: merged.mx, status: STATUS_OK};
            end
            ST_BRD: begin
                if (build_end) begin
                    res_en = 1'b1;
                    n_out  = '{range_min: '0, range_max: '0, status: STATUS_OK};
                end else if (lvl_done) begin
                    n_k = LVL_W'(r_k + 1'b1);
                    n_j = '0;
                end else begin
                    o_ram_req.re     = 1'b1;
                    o_ram_req.raddr0 = tbl_addr(LVL_W'(r_k - 1'b1), r_j);
                    o_ram_req.raddr1 = tbl_addr(LVL_W'(r_k - 1'b1),
                                                ROW_W'(int'(r_j) + (1 << (r_k - 1'b1))));
                end
            end
            ST_BWR: begin
                o_ram_req.we    = 1'b1;
                o_ram_req.waddr = tbl_addr(r_k, r_j);
                o_ram_req.wdata = merged;
                n_j             = ROW_W'(r_j + 1'b1);
            end
            default: begin
                o_ram_req = '0;
            end
        endcase
        n_out_valid = (r_out_valid && i_out_stall) || res_en;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_built     <= 1'b0;
            r_out_valid <= 1'b0;
            r_k         <= '0;
            r_j         <= '0;
        end else begin
            r_state     <= n_state;
            r_built     <= n_built;
            r_out_valid <= n_out_valid;
            r_k         <= n_k;
            r_j         <= n_j;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

endmodule
`default_nettype wire

// ===== src/stm_chk.sv =====
// port-level checker for the sparse table range min/max unit, with its bind
`default_nettype none
module stm_chk
    import stm_pkg::*;
(
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_in_valid,
    input wire logic             o_in_stall,
    input wire t_in              i_in_data,
    input wire logic             o_out_valid,
    input wire logic             i_out_stall,
    input wire t_out             o_out_data
);

    // a waiting result holds until transferred
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // no new item while a result is stuck
    a_no_accept_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |-> o_in_stall)
        else $error("item taken while result stalled");

    // a load answers in the next cycle
    a_load_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_in_data.cmd == CMD_LOAD) |=> o_out_valid)
        else $error("load result missing");

    // results with a status other than ok carry zero values
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status != STATUS_OK)
        |-> (o_out_data.range_min == '0) && (o_out_data.range_max == '0))
        else $error("nonzero values on error result");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.status == STATUS_OK) || (o_out_data.status == STATUS_BAD)
                     || (o_out_data.status == STATUS_UNBUILT))
        else $error("undefined status code");

endmodule

bind sparse_table_range_min_max_unit stm_chk u_stm_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
`default_nettype wire

// ===== test/range_query_checker.sv =====
// checker for the sparse table range min/max unit: predicts every result and compares it
`timescale 1ns / 100ps
module range_query_checker
    import stm_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire logic             i_in_stall,
    input  wire t_in              i_in_data,
    input  wire logic             i_out_valid,
    input  wire logic             i_out_stall,
    input  wire t_out             i_out_data,
    input  wire logic             i_cfg_valid,
    input  wire logic             i_cfg_ready,
    input  wire logic [LEN_W-1:0] i_cfg_data,
    output int                    o_pending,
    output int                    o_fail_count
);

    logic signed [VAL_W-1:0] min_tbl [LEVELS][MAX_LENGTH];
    logic signed [VAL_W-1:0] max_tbl [LEVELS][MAX_LENGTH];
    logic                    tables_ready;
    logic [LEN_W-1:0]        length_reg;
    t_out                    expected_results [$];
    int                      fails = 0;

    function automatic logic signed [VAL_W-1:0] lesser(input logic signed [VAL_W-1:0] a,
                                                       input logic signed [VAL_W-1:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic signed [VAL_W-1:0] greater(input logic signed [VAL_W-1:0] a,
                                                        input logic signed [VAL_W-1:0] b);
        return (a > b) ? a : b;
    endfunction

    function automatic logic signed [VAL_W-1:0] widen_value(input logic [VAL_W-1:0] x);
        logic signed [VAL_W-1:0] v;
        v = x;
        v = v <<< (VAL_W - SEXT_W);
        v = v >>> (VAL_W - SEXT_W);
        return v;
    endfunction

    function automatic int used_length();
        int n;
        n = int'(length_reg);
        if (n > MAX_LENGTH) begin
            n = MAX_LENGTH;
        end
        if (n > (1 << LEVELS) - 1) begin
            n = (1 << LEVELS) - 1;
        end
        return n;
    endfunction

    function automatic void rebuild_tables();
        int n;
        int span;
        n = used_length();
        for (int k = 1; k < LEVELS; k++) begin
            span = 1 << k;
            for (int j = 0; j + span <= n; j++) begin
                min_tbl[k][j] = lesser(min_tbl[k-1][j], min_tbl[k-1][j + span / 2]);
                max_tbl[k][j] = greater(max_tbl[k-1][j], max_tbl[k-1][j + span / 2]);
            end
        end
    endfunction

    function automatic t_out range_result(input t_in item);
        t_out res;
        int   n;
        int   k;
        int   lo;
        int   hi;
        res        = '0;
        res.status = STATUS_OK;
        n          = used_length();
        lo         = int'(item.left_index);
        hi         = int'(item.right_index);
        case (item.cmd)
            CMD_LOAD: begin
                if (lo < MAX_LENGTH) begin
                    min_tbl[0][lo] = widen_value(item.value_a);
                    max_tbl[0][lo] = widen_value(item.value_b);
                end else begin
                    res.status = STATUS_BAD;
                end
                tables_ready = 1'b0;
            end
            CMD_BUILD: begin
                rebuild_tables();
                tables_ready = 1'b1;
            end
            CMD_QUERY: begin
                if (!tables_ready) begin
                    res.status = STATUS_UNBUILT;
                end else if (lo > hi || hi >= n) begin
                    res.status = STATUS_BAD;
                end else begin
                    k = 0;
                    while ((2 << k) <= hi - lo + 1) begin
                        k++;
                    end
                    res.range_min = lesser(min_tbl[k][lo], min_tbl[k][hi + 1 - (1 << k)]);
                    res.range_max = greater(max_tbl[k][lo], max_tbl[k][hi + 1 - (1 << k)]);
                end
            end
            default: begin
                res.status = STATUS_BAD;
            end
        endcase
        return res;
    endfunction

    initial begin
        for (int k = 0; k < LEVELS; k++) begin
            for (int j = 0; j < MAX_LENGTH; j++) begin
                min_tbl[k][j] = '0;
                max_tbl[k][j] = '0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_out got;
        t_out want;
        if (!i_rst_n) begin
            tables_ready = 1'b0;
            length_reg   = LEN_W'(1);
            expected_results.delete();
        end else begin
            // results first, so that a result cannot meet an expectation pushed at the same edge
            if (i_out_valid && !i_out_stall) begin
                got = i_out_data;
                if (expected_results.size() == 0) begin
                    $error("result transfer with none expected: status %0d", got.status);
                    fails++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.range_min !== want.range_min) begin
                        $error("range_min: expected %0d, actual %0d",
                               want.range_min, got.range_min);
                        fails++;
                    end
                    if (got.range_max !== want.range_max) begin
                        $error("range_max: expected %0d, actual %0d",
                               want.range_max, got.range_max);
                        fails++;
                    end
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, got.status);
                        fails++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                length_reg   = i_cfg_data;
                tables_ready = 1'b0;
            end
            if (i_in_valid && !i_in_stall) begin
                expected_results.push_back(range_result(i_in_data));
            end
        end
        o_pending    <= expected_results.size();
        o_fail_count <= fails;
    end

endmodule

// ===== test/tb_top.sv =====
// testbench top for the sparse table range min/max unit: stimulus, idling and verdict
`timescale 1ns / 100ps
module tb_top
    import stm_pkg::*;
();

    localparam logic [1:0]       CMD_UNUSED = 2'd3;
    localparam logic [VAL_W-1:0] VAL_LOW    = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic [VAL_W-1:0] VAL_HIGH   = {1'b0, {(VAL_W-1){1'b1}}};
    localparam int               NPHASES    = 19;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    t_in              in_data   = '0;
    logic             in_stall;
    logic             out_valid;
    logic             out_stall = 1'b0;
    t_out             out_data;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [LEN_W-1:0] cfg_data  = '0;
    int               pending;
    int               fail_count;
    int               in_idle_pct   = 0;
    int               out_stall_pct = 0;
    bit               loaded [MAX_LENGTH];

    int phase_len [0:NPHASES-1] = '{1, 2, 3, 1024, 4, 5, 7, 8, 1023, 9,
                                    16, 17, 31, 2047, 32, 33, 0, 64, 100};
    int phase_ops [0:NPHASES-1] = '{20, 20, 25, 40, 25, 25, 25, 25, 30, 25,
                                    30, 30, 30, 30, 30, 30, 10, 30, 30};

    sparse_table_range_min_max_unit i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_data (cfg_data)
    );

    range_query_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .o_pending   (pending),
        .o_fail_count(fail_count)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk) begin
        out_stall <= ($urandom_range(99) < out_stall_pct);
    end

    function automatic logic [VAL_W-1:0] rand_value();
        case ($urandom_range(7))
            0: return VAL_LOW;
            1: return VAL_HIGH;
            2: return '0;
            3: return VAL_W'(int'($urandom_range(16)) - 8);
            default: return VAL_W'($urandom);
        endcase
    endfunction

    task automatic send(input logic [1:0] cmd, input int l, input int r,
                        input logic [VAL_W-1:0] a, input logic [VAL_W-1:0] b);
        t_in item;
        item.cmd         = cmd;
        item.left_index  = IDX_W'(l);
        item.right_index = IDX_W'(r);
        item.value_a     = a;
        item.value_b     = b;
        while ($urandom_range(99) < in_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
        if (cmd == CMD_LOAD) begin
            loaded[l % MAX_LENGTH] = 1'b1;
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic set_length(input int len);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= LEN_W'(len);
        @(posedge clk);
        while (!cfg_ready) begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic run_phase(input int len, input int ops);
        int n;
        int l;
        int r;
        int pick;
        set_length(len);
        n = (len < EFF_CAP) ? len : EFF_CAP;
        // every element below the length must hold a value before a build
        for (int j = 0; j < n; j++) begin
            if (!loaded[j]) begin
                send(CMD_LOAD, j, $urandom_range(1023), rand_value(), rand_value());
            end
        end
        send(CMD_BUILD, $urandom_range(1023), $urandom_range(1023), $urandom, $urandom);
        repeat (ops) begin
            pick = $urandom_range(99);
            if (pick < 75 && n > 0) begin
                l = $urandom_range(n - 1);
                r = $urandom_range(n - 1, l);
                send(CMD_QUERY, l, r, $urandom, $urandom);
            end else if (pick < 84) begin
                send(CMD_QUERY, $urandom_range(1023), $urandom_range(1023), $urandom, $urandom);
            end else if (pick < 92) begin
                send(CMD_LOAD, $urandom_range(1023), $urandom_range(1023),
                     rand_value(), rand_value());
                if ($urandom_range(9) < 7) begin
                    send(CMD_BUILD, $urandom_range(1023), $urandom_range(1023),
                         $urandom, $urandom);
                end
            end else if (pick < 96) begin
                send(CMD_UNUSED, $urandom_range(1023), $urandom_range(1023), $urandom, $urandom);
            end else begin
                send(CMD_BUILD, $urandom_range(1023), $urandom_range(1023), $urandom, $urandom);
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        in_idle_pct   = 35;
        out_stall_pct = 66;

        // length 1 after reset
        send(CMD_QUERY, 0, 0, '0, '0);
        send(CMD_UNUSED, 1023, 1023, '1, '1);
        send(CMD_LOAD, 0, 0, VAL_LOW, VAL_HIGH);
        send(CMD_QUERY, 0, 0, '0, '0);
        send(CMD_BUILD, 0, 0, '0, '0);
        send(CMD_QUERY, 0, 0, '1, '1);
        send(CMD_QUERY, 0, 1, '0, '0);
        send(CMD_QUERY, 1, 0, '0, '0);
        send(CMD_QUERY, 1023, 1023, '0, '0);
        send(CMD_LOAD, 1023, 1023, VAL_HIGH, VAL_LOW);
        send(CMD_QUERY, 0, 0, '0, '0);

        set_length(2);
        send(CMD_LOAD, 1, 0, VAL_HIGH, VAL_LOW);
        send(CMD_BUILD, 0, 0, '0, '0);
        send(CMD_QUERY, 0, 1, '0, '0);
        send(CMD_QUERY, 1, 1, '0, '0);
        send(CMD_QUERY, 0, 0, '0, '0);

        // zero length: build fills nothing, no range passes
        set_length(0);
        send(CMD_BUILD, 0, 0, '0, '0);
        send(CMD_QUERY, 0, 0, '0, '0);

        // length above the table size saturates
        set_length(2047);
        send(CMD_QUERY, 0, 1023, '0, '0);
        send(CMD_UNUSED, 0, 0, '0, '0);

        for (int p = 0; p < NPHASES; p++) begin
            if (p < NPHASES / 3) begin
                in_idle_pct   = 35;
                out_stall_pct = 66;
            end else if (p < 2 * NPHASES / 3) begin
                in_idle_pct   = 66;
                out_stall_pct = 35;
            end else begin
                in_idle_pct   = 0;
                out_stall_pct = 0;
            end
            run_phase(phase_len[p], phase_ops[p]);
        end

        drain();
        repeat (12) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
src/stm_pkg.sv
src/stm_ram.sv
src/stm_ctrl.sv
src/sparse_table_range_min_max_unit.sv
src/stm_chk.sv
test/range_query_checker.sv
test/tb_top.sv
